FILE: design/assert_macros.svh
// Assertion macros used by the fork token mutex controller top.
// Depends on nothing; each macro expects i_clk in scope, ASSERT_CLK also i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: design/ftm_pkg.sv
// Package of the fork token mutex controller: sizes, codes and shared types.
// Used by ftm_peer_unit and fork_token_mutex_controller_top; depends on nothing.
package ftm_pkg;

    localparam int MAX_NODES = 16;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int ID_W      = 4;
    localparam int OP_W      = 3;
    localparam int KIND_W    = 2;
    localparam int PHASE_W   = 2;
    localparam int CFG_IDX_W = 2;

    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [ID_W-1:0]      t_id;
    typedef logic [MAX_NODES-1:0] t_vec;
    typedef logic [OP_W-1:0]      t_op;
    typedef logic [KIND_W-1:0]    t_kind;
    typedef logic [PHASE_W-1:0]   t_phase;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_op OP_INIT    = 3'd0;
    localparam t_op OP_REQ_RX  = 3'd1;
    localparam t_op OP_FORK_RX = 3'd2;
    localparam t_op OP_ATTEMPT = 3'd3;
    localparam t_op OP_RELEASE = 3'd4;

    localparam t_kind KIND_REQ    = 2'd0;
    localparam t_kind KIND_FORK   = 2'd1;
    localparam t_kind KIND_STATUS = 2'd2;

    localparam t_phase PH_CHECK = 2'd0;
    localparam t_phase PH_REQ   = 2'd1;
    localparam t_phase PH_FORK  = 2'd2;

    localparam t_cfg_idx CFG_LOCAL_ID   = 2'd0;
    localparam t_cfg_idx CFG_PEER_COUNT = 2'd1;

    typedef struct packed {
        logic  emit;
        t_kind kind;
        logic  clr_token;
        logic  clr_fork;
        logic  fail;
    } t_unit_res;

endpackage

FILE: design/ftm_peer_unit.sv
// Shared per-peer evaluation unit: judges one peer entry for the current scan phase.
// Depends on ftm_pkg.
module ftm_peer_unit (
    input  ftm_pkg::t_phase    i_phase,
    input  logic               i_active,
    input  logic               i_fork,
    input  logic               i_dirty,
    input  logic               i_token,
    output ftm_pkg::t_unit_res o_res
);

    always_comb begin
        o_res = '0;
        if (i_active) begin
            unique case (i_phase)
                ftm_pkg::PH_CHECK: begin
                    o_res.fail = !(i_fork && (!i_dirty || !i_token));
                end
                ftm_pkg::PH_REQ: begin
                    if (i_token && !i_fork) begin
                        o_res.emit      = 1'b1;
                        o_res.kind      = ftm_pkg::KIND_REQ;
                        o_res.clr_token = 1'b1;
                    end
                end
                ftm_pkg::PH_FORK: begin
                    if (i_fork && i_token && i_dirty) begin
                        o_res.emit     = 1'b1;
                        o_res.kind     = ftm_pkg::KIND_FORK;
                        o_res.clr_fork = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: design/fork_token_mutex_controller_top.sv
// Top level of the fork token mutex controller: sequencer, per-peer state and ports.
// Depends on ftm_pkg, ftm_peer_unit and assert_macros.svh.
// Init, request, fork and unknown ops go straight to the status beat; release runs the fork
// scan and attempts the check scan first, denied attempts then the request and fork scans.
// One item at a time; the next is taken at the edge that takes the status beat, no stalls.
// Synchronous active-low reset clears the state and the vectors, sets local_id 1, peer_count 2.
`include "assert_macros.svh"

module fork_token_mutex_controller_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ftm_pkg::t_op         i_op,
    input  ftm_pkg::t_id         i_peer,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  ftm_pkg::t_cfg_idx    i_cfg_index,
    input  ftm_pkg::t_id         i_cfg_data,
    output logic                 o_valid,
    output ftm_pkg::t_kind       o_kind,
    output ftm_pkg::t_id         o_dest,
    output logic                 o_granted,
    output logic                 o_last
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_REQ    = 3'd2;
    localparam logic [2:0] ST_FORK   = 3'd3;
    localparam logic [2:0] ST_STATUS = 3'd4;

    logic [2:0]       r_state, n_state;
    ftm_pkg::t_idx    r_idx, n_idx;
    logic             r_ok, n_ok;
    logic             r_granted, n_granted;
    ftm_pkg::t_vec    r_fork, n_fork;
    ftm_pkg::t_vec    r_dirty, n_dirty;
    ftm_pkg::t_vec    r_token, n_token;
    ftm_pkg::t_id     r_local_id;
    ftm_pkg::t_id     r_peer_count;
    logic             r_out_valid, n_out_valid;
    ftm_pkg::t_kind   r_out_kind, n_out_kind;
    ftm_pkg::t_id     r_out_dest, n_out_dest;
    logic             r_out_granted, n_out_granted;
    logic             r_out_last, n_out_last;

    ftm_pkg::t_idx      w_top;
    logic               w_active;
    logic               w_last_step;
    logic               w_sender_ok;
    ftm_pkg::t_phase    w_phase;
    ftm_pkg::t_vec      w_scan_mask;
    ftm_pkg::t_vec      w_high_mask;
    ftm_pkg::t_vec      w_low_mask;
    ftm_pkg::t_unit_res w_res;

    always_comb begin
        if (int'(r_peer_count) > ftm_pkg::MAX_NODES - 1) begin
            w_top = ftm_pkg::t_idx'(ftm_pkg::MAX_NODES - 1);
        end else begin
            w_top = ftm_pkg::t_idx'(r_peer_count);
        end
    end

    always_comb begin
        for (int i = 0; i < ftm_pkg::MAX_NODES; i++) begin
            w_scan_mask[i] = (i >= 1) && (i <= int'(w_top)) && (i != int'(r_local_id));
            w_high_mask[i] = (i >= 1) && (i <= int'(w_top)) && (i > int'(r_local_id));
            w_low_mask[i]  = (i >= 1) && (i <= int'(w_top)) && (i < int'(r_local_id));
        end
    end

    assign w_active    = (r_idx <= w_top) && (int'(r_idx) != int'(r_local_id));
    assign w_last_step = (r_idx >= w_top);
    assign w_sender_ok = (i_peer != '0) && (i_peer != r_local_id) && (i_peer <= r_peer_count)
                         && (int'(i_peer) < ftm_pkg::MAX_NODES);

    always_comb begin
        unique case (r_state)
            ST_REQ:  w_phase = ftm_pkg::PH_REQ;
            ST_FORK: w_phase = ftm_pkg::PH_FORK;
            default: w_phase = ftm_pkg::PH_CHECK;
        endcase
    end

    ftm_peer_unit u_peer_unit (
        .i_phase  (w_phase),
        .i_active (w_active),
        .i_fork   (r_fork[r_idx]),
        .i_dirty  (r_dirty[r_idx]),
        .i_token  (r_token[r_idx]),
        .o_res    (w_res)
    );

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_ok          = r_ok;
        n_granted     = r_granted;
        n_fork        = r_fork;
        n_dirty       = r_dirty;
        n_token       = r_token;
        n_out_valid   = 1'b0;
        n_out_kind    = r_out_kind;
        n_out_dest    = r_out_dest;
        n_out_granted = r_out_granted;
        n_out_last    = r_out_last;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_granted = 1'b0;
                    n_ok      = 1'b1;
                    n_idx     = ftm_pkg::t_idx'(1);
                    n_state   = ST_STATUS;
                    unique case (i_op)
                        ftm_pkg::OP_INIT: begin
                            n_fork  = r_fork | w_high_mask;
                            n_dirty = r_dirty | w_high_mask;
                            n_token = r_token | w_low_mask;
                        end
                        ftm_pkg::OP_REQ_RX: begin
                            if (w_sender_ok) begin
                                n_token[ftm_pkg::t_idx'(i_peer)] = 1'b1;
                            end
                        end
                        ftm_pkg::OP_FORK_RX: begin
                            if (w_sender_ok) begin
                                n_fork[ftm_pkg::t_idx'(i_peer)]  = 1'b1;
                                n_dirty[ftm_pkg::t_idx'(i_peer)] = 1'b0;
                            end
                        end
                        ftm_pkg::OP_ATTEMPT: n_state = ST_CHECK;
                        ftm_pkg::OP_RELEASE: n_state = ST_FORK;
                        default: begin
                        end
                    endcase
                end
            end
            ST_CHECK: begin
                n_ok = r_ok && !w_res.fail;
                if (w_last_step) begin
                    n_idx = ftm_pkg::t_idx'(1);
                    if (n_ok) begin
                        n_dirty   = r_dirty | w_scan_mask;
                        n_granted = 1'b1;
                        n_state   = ST_STATUS;
                    end else begin
                        n_state = ST_REQ;
                    end
                end else begin
                    n_idx = r_idx + ftm_pkg::t_idx'(1);
                end
            end
            ST_REQ, ST_FORK: begin
                if (w_res.clr_token) begin
                    n_token[r_idx] = 1'b0;
                end
                if (w_res.clr_fork) begin
                    n_fork[r_idx]  = 1'b0;
                    n_dirty[r_idx] = 1'b0;
                end
                if (w_res.emit) begin
                    n_out_valid   = 1'b1;
                    n_out_kind    = w_res.kind;
                    n_out_dest    = ftm_pkg::t_id'(r_idx);
                    n_out_granted = 1'b0;
                    n_out_last    = 1'b0;
                end
                if (w_last_step) begin
                    n_idx   = ftm_pkg::t_idx'(1);
                    n_state = (r_state == ST_REQ) ? ST_FORK : ST_STATUS;
                end else begin
                    n_idx = r_idx + ftm_pkg::t_idx'(1);
                end
            end
            ST_STATUS: begin
                n_out_valid   = 1'b1;
                n_out_kind    = ftm_pkg::KIND_STATUS;
                n_out_dest    = '0;
                n_out_granted = r_granted;
                n_out_last    = 1'b1;
                n_state       = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= ftm_pkg::t_idx'(1);
            r_ok         <= 1'b1;
            r_granted    <= 1'b0;
            r_fork       <= '0;
            r_dirty      <= '0;
            r_token      <= '0;
            r_local_id   <= ftm_pkg::t_id'(1);
            r_peer_count <= ftm_pkg::t_id'(2);
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_ok        <= n_ok;
            r_granted   <= n_granted;
            r_fork      <= n_fork;
            r_dirty     <= n_dirty;
            r_token     <= n_token;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    ftm_pkg::CFG_LOCAL_ID:   r_local_id   <= i_cfg_data;
                    ftm_pkg::CFG_PEER_COUNT: r_peer_count <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind    <= n_out_kind;
        r_out_dest    <= n_out_dest;
        r_out_granted <= n_out_granted;
        r_out_last    <= n_out_last;
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_dest      = r_out_dest;
    assign o_granted   = r_out_granted;
    assign o_last      = r_out_last;

    `ASSERT_CLK(a_accept_busy, start && !busy |=> busy, "Accepted item did not raise busy.")
    `ASSERT_CLK(a_status_beat, r_state == ST_STATUS |=> o_valid && o_last, "Status beat missing.")
    `ASSERT_CLK(a_last_kind, o_valid && o_last |-> o_kind == ftm_pkg::KIND_STATUS, "Bad last beat.")
    `ASSERT_ALWAYS(a_grant_last, o_valid && o_granted |-> o_last, "Grant on a message beat.")

endmodule
